>>> rtl/ewq_pkg.sv
// Shared constants and codes for the one-way elevator request queue.
package ewq_pkg;

  localparam int QUEUE_DEPTH_DEF = 128;
  localparam int TAG_WIDTH_DEF   = 16;
  localparam int ADDR_W          = 32;
  localparam int PART_W          = 2;
  localparam int QCOUNT_W        = 8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_ENQ    = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_SERVED = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

endpackage

>>> rtl/ewq_if.sv
// Valid/ready channel interfaces for request items and result items.
interface ewq_in_if #(
  parameter int TAG_WIDTH = ewq_pkg::TAG_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [ewq_pkg::ADDR_W-1:0] block_address;
  logic [TAG_WIDTH-1:0]       request_tag;
  logic                       request_is_write;
  logic [ewq_pkg::PART_W-1:0] partition;

  modport source (output valid, operation, block_address, request_tag, request_is_write,
                  partition, input ready);
  modport sink   (input valid, operation, block_address, request_tag, request_is_write,
                  partition, output ready);
endinterface

interface ewq_out_if #(
  parameter int TAG_WIDTH = ewq_pkg::TAG_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [ewq_pkg::ADDR_W-1:0]   served_address;
  logic [TAG_WIDTH-1:0]         served_tag;
  logic                         served_is_write;
  logic [ewq_pkg::PART_W-1:0]   served_partition;
  logic [ewq_pkg::QCOUNT_W-1:0] queued_count;

  modport source (output valid, status, served_address, served_tag, served_is_write,
                  served_partition, queued_count, input ready);
  modport sink   (input valid, status, served_address, served_tag, served_is_write,
                  served_partition, queued_count, output ready);
endinterface

>>> rtl/one_way_elevator_request_queue.sv
// Top level: one-way elevator request queue with two sorted circular sweep banks.
// Order: full and empty results go from accept through S_RESP to out valid; served results
//   pop in S_DEQ_OUT first; enqueue walks the target bank (if not empty), shifting entries up.
// Throughput: one item at a time; in ready again as the result is registered.
// The insertion walk (one bank read, one key compare, one bank write per cycle) sets the rate.
// Reset: synchronous; sweep counts and control clear; bank contents are left as they are.
module one_way_elevator_request_queue #(
  parameter int QUEUE_DEPTH = ewq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = ewq_pkg::TAG_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ewq_in_if.sink    in_if,
  ewq_out_if.source out_if
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int IDX_W1 = IDX_W + 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W1 = CNT_W + 1;
  localparam int ADDR_W = ewq_pkg::ADDR_W;
  localparam int PART_W = ewq_pkg::PART_W;
  localparam int PAY_W  = TAG_WIDTH + 1 + PART_W;
  localparam int ENT_W  = ADDR_W + PAY_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] key_t;
  typedef logic [PAY_W-1:0]  pay_t;
  typedef logic [ENT_W-1:0]  ent_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD_CMP,   // compare new key with current sweep head
    S_INS_START,  // locate tail of target bank
    S_INS_WALK,   // shift entries up while new key is lower
    S_INS_PUT,    // drop new entry at the front
    S_DEQ_OUT,    // pop head of current sweep
    S_RESP        // hand result to output register
  } state_t;

  localparam idx_t LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  function automatic idx_t idx_inc(input idx_t x);
    idx_t r;
    r = (x == LAST_IDX) ? '0 : x + idx_t'(1);
    return r;
  endfunction

  function automatic idx_t idx_dec(input idx_t x);
    idx_t r;
    r = (x == '0) ? LAST_IDX : x - idx_t'(1);
    return r;
  endfunction

  // Control and working registers
  state_t           state_r,    state_nxt;
  logic             cur_bank_r, cur_bank_nxt;   // physical bank holding the current sweep
  logic             tgt_cur_r,  tgt_cur_nxt;    // insert goes to current sweep
  cnt_t             cur_cnt_r,  cur_cnt_nxt;
  cnt_t             nxt_cnt_r,  nxt_cnt_nxt;
  idx_t             cur_head_r, cur_head_nxt;
  idx_t             nxt_head_r, nxt_head_nxt;
  idx_t             wr_ptr_r,   wr_ptr_nxt;
  idx_t             rd_ptr_r,   rd_ptr_nxt;
  cnt_t             rem_r,      rem_nxt;        // entries still to examine in the walk
  key_t             key_r,      key_nxt;
  pay_t             pay_r,      pay_nxt;
  ewq_pkg::status_t status_r,   status_nxt;
  key_t             srv_key_r,  srv_key_nxt;
  pay_t             srv_pay_r,  srv_pay_nxt;

  // Output register
  logic                         out_valid_r,  out_valid_nxt;
  ewq_pkg::status_t             out_status_r, out_status_nxt;
  key_t                         out_key_r,    out_key_nxt;
  pay_t                         out_pay_r,    out_pay_nxt;
  logic [ewq_pkg::QCOUNT_W-1:0] out_qcnt_r,   out_qcnt_nxt;

  // Bank ports
  logic [1:0] mem_we;
  idx_t       mem_waddr;
  ent_t       mem_wdata;
  idx_t       mem_raddr;
  ent_t       mem_rdata [2];

  // Datapath
  logic       in_acc;
  logic       tgt_bank;
  logic       rd_bank;
  ent_t       ent;
  key_t       ent_key;
  pay_t       ent_pay;
  ent_t       new_ent;
  cnt_t       total;
  cnt_t       tgt_cnt;
  idx_t       tgt_head;
  logic [IDX_W1-1:0] tail_sum;
  idx_t       tail;
  key_t       cmp_a;
  key_t       cmp_b;
  logic       cmp_lt;
  logic       wr_en;
  logic       ins_done;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    ewq_bank #(
      .DEPTH   (QUEUE_DEPTH),
      .ENTRY_W (ENT_W)
    ) u_bank (
      .clk   (clk),
      .we    (mem_we[b]),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata[b])
    );
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && (state_r == S_IDLE);

  assign tgt_bank = tgt_cur_r ? cur_bank_r : ~cur_bank_r;
  assign rd_bank  = (state_r == S_INS_WALK) ? tgt_bank : cur_bank_r;
  assign ent      = rd_bank ? mem_rdata[1] : mem_rdata[0];
  assign ent_key  = ent[ADDR_W-1:0];
  assign ent_pay  = ent[ENT_W-1:ADDR_W];
  assign new_ent  = {pay_r, key_r};

  assign total    = cur_cnt_r + nxt_cnt_r;
  assign tgt_cnt  = tgt_cur_r ? cur_cnt_r : nxt_cnt_r;
  assign tgt_head = tgt_cur_r ? cur_head_r : nxt_head_r;

  // tail = (head + count) mod depth; both terms below depth so one subtract suffices
  assign tail_sum = IDX_W1'(tgt_head) + IDX_W1'(tgt_cnt);
  assign tail     = (tail_sum >= IDX_W1'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - IDX_W1'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

  // Shared key comparator: head < key at the head check, key < entry in the walk
  assign cmp_a  = (state_r == S_HEAD_CMP) ? ent_key : key_r;
  assign cmp_b  = (state_r == S_HEAD_CMP) ? key_r : ent_key;
  assign cmp_lt = cmp_a < cmp_b;

  assign mem_we[0] = wr_en && !tgt_bank;
  assign mem_we[1] = wr_en && tgt_bank;

  always_comb begin
    state_nxt      = state_r;
    cur_bank_nxt   = cur_bank_r;
    tgt_cur_nxt    = tgt_cur_r;
    cur_cnt_nxt    = cur_cnt_r;
    nxt_cnt_nxt    = nxt_cnt_r;
    cur_head_nxt   = cur_head_r;
    nxt_head_nxt   = nxt_head_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    rem_nxt        = rem_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    status_nxt     = status_r;
    srv_key_nxt    = srv_key_r;
    srv_pay_nxt    = srv_pay_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_qcnt_nxt   = out_qcnt_r;
    wr_en          = 1'b0;
    mem_waddr      = wr_ptr_r;
    mem_wdata      = new_ent;
    mem_raddr      = rd_ptr_r;
    ins_done       = 1'b0;

    case (state_r)
      S_IDLE: begin
        // pre-read the head that a dequeue or the sweep choice will need
        mem_raddr = (cur_cnt_r == '0) ? nxt_head_r : cur_head_r;
        if (in_acc) begin
          key_nxt     = in_if.block_address;
          pay_nxt     = {in_if.partition, in_if.request_is_write, in_if.request_tag};
          srv_key_nxt = '0;
          srv_pay_nxt = '0;
          if (in_if.operation == ewq_pkg::OP_ENQ) begin
            if (total >= CNT_W'(QUEUE_DEPTH)) begin
              status_nxt = ewq_pkg::STAT_FULL;
              state_nxt  = S_RESP;
            end else if (cur_cnt_r == '0) begin
              status_nxt  = ewq_pkg::STAT_ENQ;
              tgt_cur_nxt = 1'b1;
              state_nxt   = S_INS_START;
            end else begin
              status_nxt = ewq_pkg::STAT_ENQ;
              state_nxt  = S_HEAD_CMP;
            end
          end else if (total == '0) begin
            status_nxt = ewq_pkg::STAT_EMPTY;
            state_nxt  = S_RESP;
          end else begin
            status_nxt = ewq_pkg::STAT_SERVED;
            if (cur_cnt_r == '0) begin
              // promote: next sweep becomes current by swapping banks
              cur_bank_nxt = ~cur_bank_r;
              cur_head_nxt = nxt_head_r;
              nxt_head_nxt = cur_head_r;
              cur_cnt_nxt  = nxt_cnt_r;
              nxt_cnt_nxt  = '0;
            end
            state_nxt = S_DEQ_OUT;
          end
        end
      end

      S_HEAD_CMP: begin
        tgt_cur_nxt = cmp_lt;
        state_nxt   = S_INS_START;
      end

      S_INS_START: begin
        if (tgt_cnt == '0) begin
          wr_en     = 1'b1;
          mem_waddr = tail;
          ins_done  = 1'b1;
        end else begin
          mem_raddr  = idx_dec(tail);
          wr_ptr_nxt = tail;
          rd_ptr_nxt = idx_dec(tail);
          rem_nxt    = tgt_cnt;
          state_nxt  = S_INS_WALK;
        end
      end

      S_INS_WALK: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          // entry is above the new key: move it up one slot
          mem_wdata  = ent;
          wr_ptr_nxt = rd_ptr_r;
          mem_raddr  = idx_dec(rd_ptr_r);
          rd_ptr_nxt = idx_dec(rd_ptr_r);
          rem_nxt    = rem_r - cnt_t'(1);
          if (rem_r == cnt_t'(1)) begin
            state_nxt = S_INS_PUT;
          end
        end else begin
          ins_done = 1'b1;
        end
      end

      S_INS_PUT: begin
        wr_en    = 1'b1;
        ins_done = 1'b1;
      end

      S_DEQ_OUT: begin
        srv_key_nxt  = ent_key;
        srv_pay_nxt  = ent_pay;
        cur_head_nxt = idx_inc(cur_head_r);
        cur_cnt_nxt  = cur_cnt_r - cnt_t'(1);
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_key_nxt    = srv_key_r;
          out_pay_nxt    = srv_pay_r;
          out_qcnt_nxt   = ewq_pkg::QCOUNT_W'(total);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ins_done) begin
      if (tgt_cur_r) begin
        cur_cnt_nxt = cur_cnt_r + cnt_t'(1);
      end else begin
        nxt_cnt_nxt = nxt_cnt_r + cnt_t'(1);
      end
      state_nxt = S_RESP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_bank_r  <= 1'b0;
      tgt_cur_r   <= 1'b0;
      cur_cnt_r   <= '0;
      nxt_cnt_r   <= '0;
      cur_head_r  <= '0;
      nxt_head_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_bank_r  <= cur_bank_nxt;
      tgt_cur_r   <= tgt_cur_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      nxt_cnt_r   <= nxt_cnt_nxt;
      cur_head_r  <= cur_head_nxt;
      nxt_head_r  <= nxt_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wr_ptr_r     <= wr_ptr_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    rem_r        <= rem_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    status_r     <= status_nxt;
    srv_key_r    <= srv_key_nxt;
    srv_pay_r    <= srv_pay_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_qcnt_r   <= out_qcnt_nxt;
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = out_status_r;
  assign out_if.served_address   = out_key_r;
  assign out_if.served_tag       = out_pay_r[TAG_WIDTH-1:0];
  assign out_if.served_is_write  = out_pay_r[TAG_WIDTH];
  assign out_if.served_partition = out_pay_r[PAY_W-1:TAG_WIDTH+1];
  assign out_if.queued_count     = out_qcnt_r;

  // both sweeps together never exceed the queue depth
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W1'(cur_cnt_r) + CNT_W1'(nxt_cnt_r)) <= CNT_W1'(QUEUE_DEPTH))
    else $error("sweep counts exceed queue depth");

  // a pop only ever happens on a non-empty current sweep (after promotion)
  a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ_OUT) |-> (cur_cnt_r != '0))
    else $error("pop from empty current sweep");

  // the walk always has an entry left to examine
  a_walk_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WALK) |-> (rem_r != '0))
    else $error("insertion walk ran past the head");

  // bank writes come from the insert sequence only
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we != 2'b00) |-> (state_r == S_INS_START || state_r == S_INS_WALK ||
                           state_r == S_INS_PUT))
    else $error("bank write outside insert");

  // a successful enqueue grows the total by exactly one
  a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ins_done |=> (CNT_W1'(cur_cnt_r) + CNT_W1'(nxt_cnt_r)) ==
                 (CNT_W1'($past(cur_cnt_r)) + CNT_W1'($past(nxt_cnt_r)) + CNT_W1'(1)))
    else $error("enqueue did not add one entry");

endmodule

>>> rtl/ewq_bank.sv
// One sweep bank: single write port, single registered read port.
module ewq_bank #(
  parameter int DEPTH   = ewq_pkg::QUEUE_DEPTH_DEF,
  parameter int ENTRY_W = ewq_pkg::ADDR_W + ewq_pkg::TAG_WIDTH_DEF + 1 + ewq_pkg::PART_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [ENTRY_W-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [ENTRY_W-1:0]       rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> tb/one_way_elevator_request_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the one-way elevator request queue.
module one_way_elevator_request_queue_tb;

  localparam int QUEUE_DEPTH = ewq_pkg::QUEUE_DEPTH_DEF;
  localparam int TAG_W       = ewq_pkg::TAG_WIDTH_DEF;
  localparam int ADDR_W      = ewq_pkg::ADDR_W;
  localparam int PART_W      = ewq_pkg::PART_W;
  localparam int QCOUNT_W    = ewq_pkg::QCOUNT_W;
  localparam int RAND_ITEMS  = 1350;
  // No handshake on either side for this long means the block has hung.
  // Worst honest quiet spell: long hold-off (HOLD_LEN) + full insert walk + sender gap.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_LEN    = 600;
  localparam int HOLD_AT_A   = 2000;
  localparam int HOLD_AT_B   = 12000;

  // One request item as offered on the input channel.
  typedef struct packed {
    ewq_pkg::op_t       op;
    logic [ADDR_W-1:0]  addr;
    logic [TAG_W-1:0]   tag;
    logic               wr;
    logic [PART_W-1:0]  part;
  } req_t;

  // One result item.
  typedef struct packed {
    ewq_pkg::status_t    status;
    logic [ADDR_W-1:0]   served_address;
    logic [TAG_W-1:0]    served_tag;
    logic                served_is_write;
    logic [PART_W-1:0]   served_partition;
    logic [QCOUNT_W-1:0] queued_count;
  } result_t;

  // Directed stimulus row; 'typed' rows carry a hand-written result.
  typedef struct packed {
    req_t    req;
    logic    typed;
    result_t want;
  } row_t;

  // Entry held in a sweep of the predictor.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  tag;
    logic              wr;
    logic [PART_W-1:0] part;
  } sweep_entry_t;

  typedef enum int {PH_MIX, PH_FILL, PH_DRAIN} phase_t;

  logic clk;
  logic rst_n;

  ewq_in_if  #(.TAG_WIDTH(TAG_W)) in_ch ();
  ewq_out_if #(.TAG_WIDTH(TAG_W)) out_ch ();

  one_way_elevator_request_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Predictor state: the two address-sorted sweeps.
  sweep_entry_t sweep_now[$];
  sweep_entry_t sweep_later[$];

  // Results still owed by the block, oldest first.
  result_t awaited_results[$];

  // Typed expectation travelling alongside the item on the input channel.
  logic    row_typed;
  result_t row_want;

  int unsigned burst_left;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned items_in;
  int unsigned n_enq, n_full, n_served, n_empty;
  int unsigned deepest;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // First slot whose key is strictly above addr: equal keys stay in arrival order.
  function automatic int unsigned insert_point(input sweep_entry_t q[$],
                                               input logic [ADDR_W-1:0] addr);
    int unsigned pos;
    pos = 0;
    while (pos < q.size() && !(addr < q[pos].addr)) pos++;
    return pos;
  endfunction

  // Applies one request to the sweeps and returns the result it causes.
  function automatic result_t schedule_request(input req_t r);
    result_t      res;
    sweep_entry_t ent;
    int unsigned  total;
    res.status           = ewq_pkg::STAT_ENQ;
    res.served_address   = '0;
    res.served_tag       = '0;
    res.served_is_write  = 1'b0;
    res.served_partition = '0;
    total = sweep_now.size() + sweep_later.size();
    if (r.op == ewq_pkg::OP_ENQ) begin
      if (total >= QUEUE_DEPTH) begin
        // full: request dropped, nothing moves
        res.status = ewq_pkg::STAT_FULL;
      end else begin
        ent = '{addr: r.addr, tag: r.tag, wr: r.wr, part: r.part};
        // joins this sweep if it is empty or the request lies strictly ahead of the head
        if (sweep_now.size() == 0 || r.addr > sweep_now[0].addr) begin
          sweep_now.insert(insert_point(sweep_now, r.addr), ent);
        end else begin
          sweep_later.insert(insert_point(sweep_later, r.addr), ent);
        end
      end
    end else if (total == 0) begin
      res.status = ewq_pkg::STAT_EMPTY;
    end else begin
      // sweep exhausted: wrap round to the next one
      if (sweep_now.size() == 0) begin
        sweep_now = sweep_later;
        sweep_later.delete();
      end
      ent = sweep_now.pop_front();
      res.status           = ewq_pkg::STAT_SERVED;
      res.served_address   = ent.addr;
      res.served_tag       = ent.tag;
      res.served_is_write  = ent.wr;
      res.served_partition = ent.part;
    end
    total = sweep_now.size() + sweep_later.size();
    res.queued_count = QCOUNT_W'(total);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and scoreboard: both channels sampled on the same edge, values
  // seen here are the pre-edge ones since everything is driven by NBA.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    req_t    req;
    result_t pred;
    result_t exp_r;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        req.op   = ewq_pkg::op_t'(in_ch.operation);
        req.addr = in_ch.block_address;
        req.tag  = in_ch.request_tag;
        req.wr   = in_ch.request_is_write;
        req.part = in_ch.partition;
        pred = schedule_request(req);
        // a hand-written result takes the place of the prediction
        awaited_results.push_back(row_typed ? row_want : pred);
        items_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result item: status %0d count %0d",
                 out_ch.status, out_ch.queued_count);
          fail_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_ch.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.served_address !== exp_r.served_address) begin
            $error("served_address: expected %h, got %h",
                   exp_r.served_address, out_ch.served_address);
            fail_count++;
          end
          if (out_ch.served_tag !== exp_r.served_tag) begin
            $error("served_tag: expected %h, got %h", exp_r.served_tag, out_ch.served_tag);
            fail_count++;
          end
          if (out_ch.served_is_write !== exp_r.served_is_write) begin
            $error("served_is_write: expected %b, got %b",
                   exp_r.served_is_write, out_ch.served_is_write);
            fail_count++;
          end
          if (out_ch.served_partition !== exp_r.served_partition) begin
            $error("served_partition: expected %0d, got %0d",
                   exp_r.served_partition, out_ch.served_partition);
            fail_count++;
          end
          if (out_ch.queued_count !== exp_r.queued_count) begin
            $error("queued_count: expected %0d, got %0d",
                   exp_r.queued_count, out_ch.queued_count);
            fail_count++;
          end
          case (exp_r.status)
            ewq_pkg::STAT_ENQ:    n_enq++;
            ewq_pkg::STAT_FULL:   n_full++;
            ewq_pkg::STAT_SERVED: n_served++;
            default:              n_empty++;
          endcase
          if (32'(exp_r.queued_count) > deepest) deepest = 32'(exp_r.queued_count);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hang detector: no item moved on either side for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, re-chosen each time the current mode runs out, plus
  // two long hold-offs so the block backs up and drops in ready.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned cyc;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned mode;
    logic [15:0] pat;
    cyc       = 0;
    mode_left = 0;
    hold_left = 0;
    mode      = 0;
    pat       = '1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) hold_left = HOLD_LEN;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 400);
        pat       = 16'($urandom);
      end
      mode_left--;
      pat = {pat[14:0], pat[15]};
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;               // no stalls
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= pat[0];             // rotating pattern
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  function automatic row_t mk_row(input ewq_pkg::op_t op, input logic [ADDR_W-1:0] addr,
                                  input logic [TAG_W-1:0] tag, input logic wr,
                                  input logic [PART_W-1:0] part, input logic typed,
                                  input ewq_pkg::status_t st,
                                  input logic [ADDR_W-1:0] s_addr,
                                  input logic [TAG_W-1:0] s_tag, input logic s_wr,
                                  input logic [PART_W-1:0] s_part,
                                  input logic [QCOUNT_W-1:0] cnt);
    row_t r;
    r.req  = '{op: op, addr: addr, tag: tag, wr: wr, part: part};
    r.typed = typed;
    r.want = '{status: st, served_address: s_addr, served_tag: s_tag,
               served_is_write: s_wr, served_partition: s_part, queued_count: cnt};
    return r;
  endfunction

  // Address mix: clustered small keys for ties, the extremes, and full range.
  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ADDR_W'($urandom_range(0, 15));
      4:          return '0;
      5:          return '1;
      6:          return {{(ADDR_W-4){1'b1}}, 4'($urandom_range(0, 15))};
      default:    return ADDR_W'($urandom);
    endcase
  endfunction

  function automatic row_t random_row(input phase_t ph);
    row_t        r;
    int unsigned deq_pct;
    case (ph)
      PH_FILL:  deq_pct = 5;
      PH_DRAIN: deq_pct = 90;
      default:  deq_pct = 50;
    endcase
    r = '0;
    r.req.op   = ($urandom_range(0, 99) < deq_pct) ? ewq_pkg::OP_DEQ : ewq_pkg::OP_ENQ;
    // dequeues still carry random junk in the unused fields
    r.req.addr = pick_address();
    r.req.tag  = TAG_W'($urandom);
    r.req.wr   = 1'($urandom_range(0, 1));
    r.req.part = PART_W'($urandom_range(0, 3));
    r.typed    = 1'b0;
    return r;
  endfunction

  // Offers one item and returns on the edge it is taken. Bursts of random
  // length with random gaps; valid stays high across back-to-back items.
  task automatic send_item(input row_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 8);
      burst_left = $urandom_range(1, 32);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid            <= 1'b1;
    in_ch.operation        <= r.req.op;
    in_ch.block_address    <= r.req.addr;
    in_ch.request_tag      <= r.req.tag;
    in_ch.request_is_write <= r.req.wr;
    in_ch.partition        <= r.req.part;
    row_typed              <= r.typed;
    row_want               <= r.want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    row_t        dir_rows[$];
    phase_t      ph;
    int unsigned sent;
    int unsigned ph_left;
    int unsigned k;

    fail_count   = 0;
    items_in     = 0;
    n_enq        = 0;
    n_full       = 0;
    n_served     = 0;
    n_empty      = 0;
    deepest      = 0;
    burst_left   = 0;
    quiet_cycles = 0;

    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.operation        <= ewq_pkg::OP_ENQ;
    in_ch.block_address    <= '0;
    in_ch.request_tag      <= '0;
    in_ch.request_is_write <= 1'b0;
    in_ch.partition        <= '0;
    row_typed              <= 1'b0;
    row_want               <= '0;

    // Directed walk through both sweeps, ties, wrap-round and the empty case.
    // Typed rows are the ones obvious by inspection; the rest use the predictor.
    // dequeue on empty straight after reset, junk in the ignored fields
    dir_rows.push_back(mk_row(ewq_pkg::OP_DEQ, 32'hDEAD_BEEF, 16'hA5A5, 1, 3,
                              1, ewq_pkg::STAT_EMPTY, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd100, 16'h1234, 1, 2,
                              1, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 1));
    // top address, all-ones payload: ahead of head, same sweep
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1, 3,
                              1, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 2));
    // equal to the head: must wait for the next sweep
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd100, 16'h0001, 0, 1,
                              1, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 3));
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd0, 16'h0000, 0, 0,
                              1, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 4));
    // tie inside the current sweep keeps arrival order
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd200, 16'h0AAA, 0, 0,
                              0, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd200, 16'h0BBB, 1, 1,
                              0, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd50,  16'h0CCC, 0, 2,
                              0, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ewq_pkg::OP_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1, 3,
                              1, ewq_pkg::STAT_SERVED, 32'd100, 16'h1234, 1, 2, 6));
    // head is now 200: 150 goes behind, 201 ahead
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd150, 16'h0DDD, 1, 0,
                              0, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd201, 16'h0EEE, 0, 3,
                              0, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 0));
    for (k = 0; k < 4; k++)
      dir_rows.push_back(mk_row(ewq_pkg::OP_DEQ, $urandom, 16'h5A5A, 0, 1,
                                0, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 0));
    // current sweep empty, next one not: a new request starts a fresh sweep
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd7, 16'h0F0F, 1, 1,
                              0, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 0));
    // serve it, then wrap round: address zero, tag zero, but a served status
    for (k = 0; k < 5; k++)
      dir_rows.push_back(mk_row(ewq_pkg::OP_DEQ, 32'h0, 16'h0, 0, 0,
                                0, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ewq_pkg::OP_DEQ, 32'h8000_0001, 16'h8001, 1, 2,
                              1, ewq_pkg::STAT_EMPTY, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(ewq_pkg::OP_ENQ, 32'd0, 16'hFFFF, 1, 3,
                              1, ewq_pkg::STAT_ENQ, 0, 0, 0, 0, 1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random part in phases: fill to the brim (rejects when full), drain past
    // empty, then randomly chosen fill, drain or mixed phases, mixed ones of random length.
    sent    = 0;
    ph      = PH_FILL;
    ph_left = 150;
    while (sent < RAND_ITEMS) begin
      if (ph_left == 0) begin
        case ($urandom_range(0, 5))
          0:       begin ph = PH_FILL;  ph_left = 150; end
          1:       begin ph = PH_DRAIN; ph_left = 160; end
          default: begin ph = PH_MIX;   ph_left = $urandom_range(20, 80); end
        endcase
        // the first fill is always followed by a full drain
        if (sent == 150) begin
          ph      = PH_DRAIN;
          ph_left = 160;
        end
      end
      send_item(random_row(ph));
      ph_left--;
      sent++;
    end
    in_ch.valid <= 1'b0;

    // Let every owed result arrive, then watch a little longer for strays.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);

    $display("covered %0d requests: %0d enqueued, %0d rejected as full, %0d served",
             items_in, n_enq, n_full, n_served);
    $display("  %0d dequeues on an empty queue, deepest fill %0d of %0d",
             n_empty, deepest, QUEUE_DEPTH);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ewq_pkg.sv
rtl/ewq_if.sv
rtl/ewq_bank.sv
rtl/one_way_elevator_request_queue.sv
tb/one_way_elevator_request_queue_tb.sv
